FILE: hw/rtl/dsga_pkg.sv
// ----------------------------------------------------------------------------
// dsga_pkg: shared definitions for the direct-sum gravity accumulator
// Sizes, operation codes, register indexes and the request payload types.
// ----------------------------------------------------------------------------
package dsga_pkg;

  // Body store geometry.
  localparam int MAX_BODIES = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;

  // Datapath widths of the shared iterative unit.
  localparam int XW = 105;  // numerator and wide product
  localparam int YW = 99;   // divisor (d cubed) and multiplier
  localparam int RW = 99;   // remainder and square-root bit

  // Shared unit operation codes.
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_GRAV = 1'b0;
  localparam logic CFG_MIND = 1'b1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [31:0] body_mass;
    logic signed [31:0] start_acc_x;
    logic signed [31:0] start_acc_y;
    logic signed [31:0] start_acc_z;
    logic               affected;
    logic               exerts;
    logic               last_body;
  } in_item_t;

  typedef struct packed {
    logic        [5:0]  body_index;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic               saturated;
    logic               last_result;
  } out_item_t;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } unit_req_t;

endpackage

FILE: hw/rtl/dsga_in_if.sv
// ----------------------------------------------------------------------------
// dsga_in_if: body load channel
// Valid/ready channel that carries one body per request.
// ----------------------------------------------------------------------------
interface dsga_in_if;
  logic              valid;
  logic              ready;
  dsga_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/dsga_out_if.sv
// ----------------------------------------------------------------------------
// dsga_out_if: acceleration result channel
// Valid/ready channel that carries one body result per request.
// ----------------------------------------------------------------------------
interface dsga_out_if;
  logic               valid;
  logic               ready;
  dsga_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/dsga_unit.sv
// ----------------------------------------------------------------------------
// dsga_unit: shared iterative arithmetic unit
// Shift-add multiply, restoring divide and integer square root, one step
// per cycle. The result is held in z after done pulses.
// ----------------------------------------------------------------------------
module dsga_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dsga_pkg::unit_req_t     req_i,
  input  logic [dsga_pkg::XW-1:0] a_i,
  input  logic [dsga_pkg::YW-1:0] b_i,
  output logic [dsga_pkg::XW-1:0] res_o,
  output logic                    done_o
);

  logic [dsga_pkg::XW-1:0] x_q, x_d, z_q, z_d;
  logic [dsga_pkg::YW-1:0] y_q, y_d;
  logic [dsga_pkg::RW-1:0] r_q, r_d;
  logic [1:0]              op_q;
  logic [6:0]              cnt_q, last_cnt;
  logic                    busy_q, done_q;

  logic [dsga_pkg::RW:0]   rr;
  logic                    rr_ge;
  logic [63:0]             sq_t;

  // Step count per operation.
  always_comb begin
    unique case (op_q)
      dsga_pkg::OP_DIV:  last_cnt = 7'(dsga_pkg::XW - 1);
      dsga_pkg::OP_SQRT: last_cnt = 7'd31;
      default:           last_cnt = 7'd32;
    endcase
  end

  // One iteration of the selected operation.
  always_comb begin
    rr    = {r_q, x_q[dsga_pkg::XW-1]};
    rr_ge = rr >= {1'b0, y_q};
    sq_t  = z_q[63:0] + r_q[63:0];
    x_d   = x_q;
    y_d   = y_q;
    z_d   = z_q;
    r_d   = r_q;
    unique case (op_q)
      dsga_pkg::OP_DIV: begin
        r_d = rr_ge ? dsga_pkg::RW'(rr - {1'b0, y_q}) : rr[dsga_pkg::RW-1:0];
        z_d = {z_q[dsga_pkg::XW-2:0], rr_ge};
        x_d = {x_q[dsga_pkg::XW-2:0], 1'b0};
      end
      dsga_pkg::OP_SQRT: begin
        if (x_q[63:0] >= sq_t) begin
          x_d = {x_q[dsga_pkg::XW-1:64], x_q[63:0] - sq_t};
          z_d = dsga_pkg::XW'((z_q[63:0] >> 1) + r_q[63:0]);
        end else begin
          z_d = dsga_pkg::XW'(z_q[63:0] >> 1);
        end
        r_d = r_q >> 2;
      end
      default: begin
        if (y_q[0]) begin
          z_d = z_q + x_q;
        end
        x_d = {x_q[dsga_pkg::XW-2:0], 1'b0};
        y_d = y_q >> 1;
      end
    endcase
  end

  // Operand load and iteration registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q  <= a_i;
      y_q  <= b_i;
      z_q  <= '0;
      r_q  <= (req_i.op == dsga_pkg::OP_SQRT) ? (dsga_pkg::RW'(1) << 62) : '0;
      op_q <= req_i.op;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      r_q <= r_d;
    end
  end

  // Step counter and completion flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == last_cnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign res_o  = z_q;
  assign done_o = done_q;

  // A start is never issued while an operation is still running.
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start) else $error("unit started while busy");

  // Done follows only from a busy cycle.
  a_done_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without busy");

  // The counter never runs past the last step.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= 7'(dsga_pkg::XW - 1)) else $error("step count overrun");

endmodule

FILE: hw/rtl/direct_sum_gravity_accumulator.sv
// ----------------------------------------------------------------------------
// direct_sum_gravity_accumulator: direct N-body gravity, Q16.16
// Loads a set of bodies, sums pairwise gravity with one shared iterative
// unit and returns one acceleration per body in load order.
// ----------------------------------------------------------------------------
// Bodies are taken one per cycle while the block loads; the body marked last
// (or the 64th) starts the computation and the load channel stays not ready
// until every result has been handed to the output register. All arithmetic
// runs through one iterative unit that does one multiply, divide or square
// root step per cycle; each operation has a start state that issues the
// request and a wait state that ends when the unit reports done. Each
// interacting pair is fetched and checked, then takes three squares, a square
// root, three products for G*m, d^2 and d^3, then per component a product and
// a division. A body that is not affected goes from its read and init states
// straight to the emit state, and a pair with a body that does not exert ends
// after the fetch and check states.
module direct_sum_gravity_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  dsga_in_if.sink     in_i,
  dsga_out_if.source  res_o
);

  localparam logic [4:0] S_LOAD  = 5'd0;
  localparam logic [4:0] S_IRD   = 5'd1;
  localparam logic [4:0] S_IINIT = 5'd2;
  localparam logic [4:0] S_JRD   = 5'd3;
  localparam logic [4:0] S_JCHK  = 5'd4;
  localparam logic [4:0] S_SQ    = 5'd5;
  localparam logic [4:0] S_SQW   = 5'd6;
  localparam logic [4:0] S_SQRT  = 5'd7;
  localparam logic [4:0] S_SQRTW = 5'd8;
  localparam logic [4:0] S_GM    = 5'd9;
  localparam logic [4:0] S_GMW   = 5'd10;
  localparam logic [4:0] S_D2    = 5'd11;
  localparam logic [4:0] S_D2W   = 5'd12;
  localparam logic [4:0] S_D3    = 5'd13;
  localparam logic [4:0] S_D3W   = 5'd14;
  localparam logic [4:0] S_NUM   = 5'd15;
  localparam logic [4:0] S_NUMW  = 5'd16;
  localparam logic [4:0] S_DIV   = 5'd17;
  localparam logic [4:0] S_DIVW  = 5'd18;
  localparam logic [4:0] S_EMIT  = 5'd19;

  logic [4:0]                  state_q;
  logic [31:0]                 grav_q;
  logic [30:0]                 mind_q;
  logic [dsga_pkg::CNT_W-1:0]  count_q, n_q;
  logic [dsga_pkg::IDX_W-1:0]  i_q, j_q;
  logic [1:0]                  c_q;

  // Body stores.
  logic [31:0] px_mem [dsga_pkg::MAX_BODIES];
  logic [31:0] py_mem [dsga_pkg::MAX_BODIES];
  logic [31:0] pz_mem [dsga_pkg::MAX_BODIES];
  logic [31:0] m_mem  [dsga_pkg::MAX_BODIES];
  logic [31:0] ax_mem [dsga_pkg::MAX_BODIES];
  logic [31:0] ay_mem [dsga_pkg::MAX_BODIES];
  logic [31:0] az_mem [dsga_pkg::MAX_BODIES];
  logic [1:0]  f_mem  [dsga_pkg::MAX_BODIES];

  logic [31:0] pxi_q, pyi_q, pzi_q, pxj_q, pyj_q, pzj_q, mj_q;
  logic [31:0] axi_q, ayi_q, azi_q;
  logic [1:0]  fi_q, fj_q;

  // Pair working registers.
  logic [32:0]        dmag_q [3];
  logic               dneg_q [3];
  logic signed [31:0] acc_q  [3];
  logic               clip_q;
  logic [63:0]        sum_q, gm_q;
  logic [32:0]        d_q;
  logic [65:0]        d2_q;
  logic [98:0]        d3_q;
  logic [104:0]       num_q;

  logic                     in_acc, out_acc, emit_load, last_in;
  logic [dsga_pkg::IDX_W-1:0] wa;
  dsga_pkg::unit_req_t      ureq;
  logic [dsga_pkg::XW-1:0]  ua, ures;
  logic [dsga_pkg::YW-1:0]  ub;
  logic                     udone;
  dsga_pkg::out_item_t      out_q;
  logic                     out_v_q;

  logic signed [32:0] dpx, dpy, dpz;
  logic [32:0]        sqrt_d, dmin;
  logic [32:0]        cap;
  logic signed [34:0] contrib, asum;
  logic [63:0]        sq_add;

  assign in_acc    = in_i.valid && in_i.ready;
  assign out_acc   = res_o.valid && res_o.ready;
  assign in_i.ready = (state_q == S_LOAD);
  assign wa        = count_q[dsga_pkg::IDX_W-1:0];
  assign last_in   = in_i.data.last_body ||
                     (count_q == dsga_pkg::CNT_W'(dsga_pkg::MAX_BODIES - 1));
  assign emit_load = (state_q == S_EMIT) && (!out_v_q || res_o.ready);

  // Store writes during loading.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_mem[wa] <= in_i.data.pos_x;
      py_mem[wa] <= in_i.data.pos_y;
      pz_mem[wa] <= in_i.data.pos_z;
      m_mem[wa]  <= in_i.data.body_mass;
      ax_mem[wa] <= in_i.data.start_acc_x;
      ay_mem[wa] <= in_i.data.start_acc_y;
      az_mem[wa] <= in_i.data.start_acc_z;
      f_mem[wa]  <= {in_i.data.exerts, in_i.data.affected};
    end
  end

  // Registered store reads at the current body pair.
  always_ff @(posedge clk_i) begin
    pxi_q <= px_mem[i_q];
    pyi_q <= py_mem[i_q];
    pzi_q <= pz_mem[i_q];
    axi_q <= ax_mem[i_q];
    ayi_q <= ay_mem[i_q];
    azi_q <= az_mem[i_q];
    fi_q  <= f_mem[i_q];
    pxj_q <= px_mem[j_q];
    pyj_q <= py_mem[j_q];
    pzj_q <= pz_mem[j_q];
    mj_q  <= m_mem[j_q];
    fj_q  <= f_mem[j_q];
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= 32'd65536;
      mind_q <= 31'd655;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dsga_pkg::CFG_GRAV: grav_q <= cfg_data_i;
        dsga_pkg::CFG_MIND: mind_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Pair arithmetic around the shared unit.
  always_comb begin
    dpx     = $signed({pxj_q[31], pxj_q}) - $signed({pxi_q[31], pxi_q});
    dpy     = $signed({pyj_q[31], pyj_q}) - $signed({pyi_q[31], pyi_q});
    dpz     = $signed({pzj_q[31], pzj_q}) - $signed({pzi_q[31], pzi_q});
    dmin    = (mind_q == '0) ? 33'd1 : {2'b00, mind_q};
    sqrt_d  = {ures[31:0], 1'b0};
    sq_add  = sum_q + ures[65:2];
    cap     = (ures > dsga_pkg::XW'(64'h1_0000_0000)) ? 33'h1_0000_0000 : ures[32:0];
    contrib = dneg_q[c_q] ? -$signed({2'b00, cap}) : $signed({2'b00, cap});
    asum    = $signed({{3{acc_q[c_q][31]}}, acc_q[c_q]}) + contrib;
  end

  // Unit request and operand selection.
  always_comb begin
    ureq.start = 1'b0;
    ureq.op    = dsga_pkg::OP_MUL;
    ua         = '0;
    ub         = '0;
    unique case (state_q)
      S_SQ: begin
        ureq.start = 1'b1;
        ua = dsga_pkg::XW'(dmag_q[c_q]);
        ub = dsga_pkg::YW'(dmag_q[c_q]);
      end
      S_SQRT: begin
        ureq.start = 1'b1;
        ureq.op    = dsga_pkg::OP_SQRT;
        ua = dsga_pkg::XW'(sum_q);
      end
      S_GM: begin
        ureq.start = 1'b1;
        ua = dsga_pkg::XW'(mj_q);
        ub = dsga_pkg::YW'(grav_q);
      end
      S_D2: begin
        ureq.start = 1'b1;
        ua = dsga_pkg::XW'(d_q);
        ub = dsga_pkg::YW'(d_q);
      end
      S_D3: begin
        ureq.start = 1'b1;
        ua = dsga_pkg::XW'(d2_q);
        ub = dsga_pkg::YW'(d_q);
      end
      S_NUM: begin
        ureq.start = 1'b1;
        ua = dsga_pkg::XW'(gm_q);
        ub = dsga_pkg::YW'(dmag_q[c_q]);
      end
      S_DIV: begin
        ureq.start = 1'b1;
        ureq.op    = dsga_pkg::OP_DIV;
        ua = num_q;
        ub = d3_q;
      end
      default: ;
    endcase
  end

  dsga_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ureq),
    .a_i    (ua),
    .b_i    (ub),
    .res_o  (ures),
    .done_o (udone)
  );

  // Working registers of the current pair.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IINIT: begin
        acc_q[0] <= axi_q;
        acc_q[1] <= ayi_q;
        acc_q[2] <= azi_q;
        clip_q   <= 1'b0;
      end
      S_JCHK: begin
        dmag_q[0] <= dpx[32] ? 33'(-dpx) : 33'(dpx);
        dmag_q[1] <= dpy[32] ? 33'(-dpy) : 33'(dpy);
        dmag_q[2] <= dpz[32] ? 33'(-dpz) : 33'(dpz);
        dneg_q[0] <= dpx[32];
        dneg_q[1] <= dpy[32];
        dneg_q[2] <= dpz[32];
        sum_q     <= '0;
      end
      S_SQW:   if (udone) sum_q <= sq_add;
      S_SQRTW: if (udone) d_q <= (sqrt_d < dmin) ? dmin : sqrt_d;
      S_GMW:   if (udone) gm_q <= ures[63:0];
      S_D2W:   if (udone) d2_q <= ures[65:0];
      S_D3W:   if (udone) d3_q <= ures[98:0];
      S_NUMW:  if (udone) num_q <= {ures[96:0], 8'd0};
      S_DIVW: begin
        if (udone) begin
          if (asum > 35'sd2147483647) begin
            acc_q[c_q] <= 32'sh7fff_ffff;
            clip_q     <= 1'b1;
          end else if (asum < -35'sd2147483648) begin
            acc_q[c_q] <= 32'sh8000_0000;
            clip_q     <= 1'b1;
          end else begin
            acc_q[c_q] <= asum[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  // Sequencer over bodies, pairs and components.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      c_q     <= '0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            count_q <= count_q + 1'b1;
            if (last_in) begin
              n_q     <= count_q + 1'b1;
              i_q     <= '0;
              j_q     <= '0;
              state_q <= S_IRD;
            end
          end
        end
        S_IRD: state_q <= S_IINIT;
        S_IINIT: begin
          j_q     <= '0;
          state_q <= fi_q[0] ? S_JRD : S_EMIT;
        end
        S_JRD: state_q <= S_JCHK;
        S_JCHK: begin
          c_q <= '0;
          if (j_q == i_q || !fj_q[1]) begin
            if (dsga_pkg::CNT_W'(j_q) + 1'b1 == n_q) begin
              state_q <= S_EMIT;
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= S_JRD;
            end
          end else begin
            state_q <= S_SQ;
          end
        end
        S_SQ: state_q <= S_SQW;
        S_SQW: begin
          if (udone) begin
            if (c_q == 2'd2) begin
              c_q     <= '0;
              state_q <= S_SQRT;
            end else begin
              c_q     <= c_q + 1'b1;
              state_q <= S_SQ;
            end
          end
        end
        S_SQRT:  state_q <= S_SQRTW;
        S_SQRTW: if (udone) state_q <= S_GM;
        S_GM:    state_q <= S_GMW;
        S_GMW:   if (udone) state_q <= S_D2;
        S_D2:    state_q <= S_D2W;
        S_D2W:   if (udone) state_q <= S_D3;
        S_D3:    state_q <= S_D3W;
        S_D3W:   if (udone) state_q <= S_NUM;
        S_NUM:   state_q <= S_NUMW;
        S_NUMW:  if (udone) state_q <= S_DIV;
        S_DIV:   state_q <= S_DIVW;
        S_DIVW: begin
          if (udone) begin
            if (c_q != 2'd2) begin
              c_q     <= c_q + 1'b1;
              state_q <= S_NUM;
            end else if (dsga_pkg::CNT_W'(j_q) + 1'b1 == n_q) begin
              state_q <= S_EMIT;
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= S_JRD;
            end
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            if (dsga_pkg::CNT_W'(i_q) + 1'b1 == n_q) begin
              count_q <= '0;
              state_q <= S_LOAD;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_IRD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (emit_load) begin
      out_v_q <= 1'b1;
    end else if (out_acc) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_q.body_index  <= i_q;
      out_q.acc_x       <= fi_q[0] ? acc_q[0] : axi_q;
      out_q.acc_y       <= fi_q[0] ? acc_q[1] : ayi_q;
      out_q.acc_z       <= fi_q[0] ? acc_q[2] : azi_q;
      out_q.saturated   <= fi_q[0] && clip_q;
      out_q.last_result <= (dsga_pkg::CNT_W'(i_q) + 1'b1 == n_q);
    end
  end

  assign res_o.valid = out_v_q;
  assign res_o.data  = out_q;

  // The shared unit only reports completion while a pair is in work.
  a_no_done_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> !udone) else $error("unit done while loading");

  // The store never overflows while loading.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> count_q < dsga_pkg::CNT_W'(dsga_pkg::MAX_BODIES))
    else $error("body count overflow");

  // Body indexes stay inside the loaded set during the computation.
  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_LOAD |-> (dsga_pkg::CNT_W'(i_q) < n_q && dsga_pkg::CNT_W'(j_q) < n_q))
    else $error("body index outside the set");

endmodule

FILE: tb/sv/tb_direct_sum_gravity_accumulator.sv
// ----------------------------------------------------------------------------
// tb_direct_sum_gravity_accumulator: self-checking bench for the gravity block
// Loads body sets through the load channel, predicts every per-body
// acceleration in Q16.16 with its own predictor and checks each result
// request in order. It runs under several gravity and clamp settings.
// ----------------------------------------------------------------------------
module tb_direct_sum_gravity_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMEOUT_CYCLES = 3000000;
  localparam int SETTLE_CYCLES  = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = dsga_pkg::CFG_GRAV;
  logic [31:0] cfg_data_i = '0;

  dsga_in_if  body_ch ();
  dsga_out_if acc_ch ();

  direct_sum_gravity_accumulator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (body_ch.sink),
    .res_o      (acc_ch.source)
  );

  // Predictor state: the current body set and the register copies.
  longint      set_pos [dsga_pkg::MAX_BODIES][3];
  longint      set_acc [dsga_pkg::MAX_BODIES][3];
  logic [31:0] set_mass [dsga_pkg::MAX_BODIES];
  logic        set_aff [dsga_pkg::MAX_BODIES];
  logic        set_ext [dsga_pkg::MAX_BODIES];
  int          set_count = 0;
  logic [31:0] grav_g = 32'd65536;
  logic [30:0] min_dist = 31'd655;

  dsga_pkg::in_item_t  body_queue [$];
  dsga_pkg::out_item_t accel_queue [$];
  int        fail_count = 0;
  int        cycle_count = 0;
  logic      body_taken = 1'b0;

  always #10 clk_i = ~clk_i;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Pull of one exerting body along one axis: G*m*|dp|*2^8 / d^3, signed as dp.
  function automatic longint pull_component(logic [63:0] gm, longint dp, logic [63:0] d);
    logic [127:0] num;
    logic [127:0] dw;
    logic [63:0]  mag;
    mag = (dp < 0) ? -dp : dp;
    dw = {64'd0, d};
    num = {64'd0, gm} * {64'd0, mag};
    num = num << 8;
    num = num / dw;
    num = num / dw;
    num = num / dw;
    if (num > 128'h1_0000_0000) num = 128'h1_0000_0000;
    return (dp < 0) ? -longint'(num[63:0]) : longint'(num[63:0]);
  endfunction

  // Appends one body to the pending load requests.
  function automatic void add_body(dsga_pkg::in_item_t b);
    body_queue = {body_queue, b};
  endfunction

  // Stores one accepted body; when the set ends, queues every body's result.
  function automatic void load_body(dsga_pkg::in_item_t b);
    longint      acc [3];
    longint      dp [3];
    logic [127:0] sq;
    logic [63:0] s;
    logic [63:0] d;
    logic [63:0] dmin;
    logic [63:0] gm;
    logic        clip;
    dsga_pkg::out_item_t r;
    int          n;
    if (set_count >= dsga_pkg::MAX_BODIES) set_count = 0;
    n = set_count;
    set_pos[n][0] = longint'(b.pos_x);
    set_pos[n][1] = longint'(b.pos_y);
    set_pos[n][2] = longint'(b.pos_z);
    set_acc[n][0] = longint'(b.start_acc_x);
    set_acc[n][1] = longint'(b.start_acc_y);
    set_acc[n][2] = longint'(b.start_acc_z);
    set_mass[n] = b.body_mass;
    set_aff[n] = b.affected;
    set_ext[n] = b.exerts;
    set_count = n + 1;
    if (!b.last_body && set_count < dsga_pkg::MAX_BODIES) return;
    dmin = (min_dist == 0) ? 64'd1 : {33'd0, min_dist};
    for (int i = 0; i < set_count; i++) begin
      clip = 1'b0;
      for (int c = 0; c < 3; c++) acc[c] = set_acc[i][c];
      if (set_aff[i]) begin
        for (int j = 0; j < set_count; j++) begin
          if (j == i || !set_ext[j]) continue;
          s = '0;
          for (int c = 0; c < 3; c++) begin
            dp[c] = set_pos[j][c] - set_pos[i][c];
            sq = (dp[c] < 0) ? -dp[c] : dp[c];
            sq = sq * sq;
            s = s + sq[65:2];
          end
          d = int_sqrt(s) << 1;
          if (d < dmin) d = dmin;
          gm = {32'd0, grav_g} * {32'd0, set_mass[j]};
          for (int c = 0; c < 3; c++) begin
            acc[c] = acc[c] + pull_component(gm, dp[c], d);
            if (acc[c] > 64'sd2147483647) begin
              acc[c] = 64'sd2147483647;
              clip = 1'b1;
            end else if (acc[c] < -64'sd2147483648) begin
              acc[c] = -64'sd2147483648;
              clip = 1'b1;
            end
          end
        end
      end
      r.body_index = i[5:0];
      r.acc_x = acc[0][31:0];
      r.acc_y = acc[1][31:0];
      r.acc_z = acc[2][31:0];
      r.saturated = clip;
      r.last_result = (i + 1 == set_count);
      accel_queue = {accel_queue, r};
    end
    set_count = 0;
  endfunction

  function automatic dsga_pkg::in_item_t mk_body(logic [31:0] px, logic [31:0] py,
                                                 logic [31:0] pz, logic [31:0] m,
                                                 logic [31:0] ax, logic [31:0] ay,
                                                 logic [31:0] az, logic aff, logic ext,
                                                 logic last);
    dsga_pkg::in_item_t b;
    b.pos_x = px;
    b.pos_y = py;
    b.pos_z = pz;
    b.body_mass = m;
    b.start_acc_x = ax;
    b.start_acc_y = ay;
    b.start_acc_z = az;
    b.affected = aff;
    b.exerts = ext;
    b.last_body = last;
    return b;
  endfunction

  // Mostly nearby coordinates so the pull is visible; sometimes the full range.
  function automatic logic [31:0] rand_word(int wide_pct);
    if ($urandom_range(99) < wide_pct) return $urandom;
    return $urandom_range(32'h0008_0000) - 32'h0004_0000;
  endfunction

  // Queues one random set of n bodies.
  task automatic queue_random_set(input int n);
    for (int k = 0; k < n; k++) begin
      add_body(mk_body(rand_word(25), rand_word(25), rand_word(25),
                       ($urandom_range(3) == 0) ? $urandom
                                                : $urandom_range(32'h0010_0000),
                       rand_word(20), rand_word(20), rand_word(20),
                       $urandom_range(3) != 0, $urandom_range(3) != 0,
                       k == n - 1));
    end
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    if (idx == dsga_pkg::CFG_GRAV) grav_g = value;
    else min_dist = value[30:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Holds the sender until every queued body is taken and every result is back.
  task automatic drain();
    while (body_queue.size() != 0 || accel_queue.size() != 0 || body_ch.valid)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Load channel driver: a new request only after the previous one is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      body_ch.valid <= 1'b0;
      body_ch.data <= '0;
    end else if (!body_ch.valid || body_taken) begin
      if (body_queue.size() != 0 &&
          ((cycle_count > 3000 && cycle_count < 9000) || $urandom_range(99) >= 20)) begin
        body_ch.valid <= 1'b1;
        body_ch.data <= body_queue.pop_front();
      end else begin
        body_ch.valid <= 1'b0;
      end
    end
  end

  // Result channel backpressure.
  always @(negedge clk_i) begin
    if (!rst_ni) acc_ch.ready <= 1'b0;
    else acc_ch.ready <= (cycle_count > 3000 && cycle_count < 9000) ||
                         ($urandom_range(99) >= 20);
  end

  // Monitor: predicts on each accepted body and checks each accepted result.
  always @(posedge clk_i) begin
    dsga_pkg::out_item_t want;
    cycle_count <= cycle_count + 1;
    body_taken <= body_ch.valid && body_ch.ready;
    if (rst_ni && body_ch.valid && body_ch.ready) load_body(body_ch.data);
    if (rst_ni && acc_ch.valid && acc_ch.ready) begin
      if (accel_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, acc_ch.data);
        fail_count++;
      end else begin
        want = accel_queue.pop_front();
        if (acc_ch.data.body_index !== want.body_index) begin
          $display("%0t: body_index expected %0d actual %0d", $time, want.body_index,
                   acc_ch.data.body_index);
          fail_count++;
        end
        if (acc_ch.data.acc_x !== want.acc_x) begin
          $display("%0t: acc_x expected %0d actual %0d", $time, want.acc_x,
                   acc_ch.data.acc_x);
          fail_count++;
        end
        if (acc_ch.data.acc_y !== want.acc_y) begin
          $display("%0t: acc_y expected %0d actual %0d", $time, want.acc_y,
                   acc_ch.data.acc_y);
          fail_count++;
        end
        if (acc_ch.data.acc_z !== want.acc_z) begin
          $display("%0t: acc_z expected %0d actual %0d", $time, want.acc_z,
                   acc_ch.data.acc_z);
          fail_count++;
        end
        if (acc_ch.data.saturated !== want.saturated) begin
          $display("%0t: saturated expected %0b actual %0b", $time, want.saturated,
                   acc_ch.data.saturated);
          fail_count++;
        end
        if (acc_ch.data.last_result !== want.last_result) begin
          $display("%0t: last_result expected %0b actual %0b", $time, want.last_result,
                   acc_ch.data.last_result);
          fail_count++;
        end
      end
    end
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("direct_sum_gravity_accumulator test failed");
      $finish;
    end
  end

  // Stimulus sequence: directed sets, then random sets under several settings.
  initial begin
    int budget;
    int n;
    body_ch.valid = 1'b0;
    body_ch.data = '0;
    acc_ch.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Coincident pair: zero distance clamps, zero offset gives no pull.
    add_body(mk_body(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 0, 1'b1, 1'b1, 1'b0));
    add_body(mk_body(32'h0001_0000, 0, 0, 32'h0001_0000, 5, -5, 7, 1'b1, 1'b1, 1'b1));
    // A set of a single body only sees itself.
    add_body(mk_body(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF,
                     32'h7FFF_FFFF, 32'h8000_0000, 1, 1'b1, 1'b1, 1'b1));
    // Extreme separations, extreme mass, pass-through bodies and saturated starts.
    add_body(mk_body(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                     32'h7FFF_FFF0, 32'h8000_0010, 0, 1'b1, 1'b1, 1'b0));
    add_body(mk_body(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0));
    add_body(mk_body(0, 0, 0, 0, 32'h1234_5678, 32'hEDCB_A987, 3, 1'b0, 1'b1, 1'b0));
    add_body(mk_body(32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0010, 32'hFFFF_FFFF,
                     32'h7FFF_0000, 32'h8000_FFFF, 0, 1'b1, 1'b0, 1'b1));
    // Close heavy bodies drive the sum into saturation.
    add_body(mk_body(0, 0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1'b1, 1'b1, 1'b0));
    add_body(mk_body(32'h0000_0400, 32'h0000_0200, 32'hFFFF_FC00, 32'hFFFF_FFFF,
                     32'h8000_0000, 0, 0, 1'b1, 1'b1, 1'b0));
    add_body(mk_body(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0001,
                     0, 0, 0, 1'b1, 1'b1, 1'b1));
    // Nobody exerts: every start passes through.
    add_body(mk_body(1, 2, 3, 32'h0002_0000, 9, 8, 7, 1'b1, 1'b0, 1'b0));
    add_body(mk_body(4, 5, 6, 32'h0002_0000, 6, 5, 4, 1'b1, 1'b0, 1'b1));
    drain();

    // Largest G with the tightest clamp.
    write_reg(dsga_pkg::CFG_GRAV, 32'hFFFF_FFFF);
    write_reg(dsga_pkg::CFG_MIND, 32'h0000_0001);
    budget = 0;
    while (budget < 25) begin
      n = $urandom_range(1, 5);
      queue_random_set(n);
      budget += n;
    end
    drain();

    // No gravity, widest clamp.
    write_reg(dsga_pkg::CFG_GRAV, 32'h0000_0000);
    write_reg(dsga_pkg::CFG_MIND, 32'h7FFF_FFFF);
    queue_random_set(4);
    queue_random_set(3);
    drain();

    // A zero clamp acts as one; random G.
    write_reg(dsga_pkg::CFG_GRAV, $urandom);
    write_reg(dsga_pkg::CFG_MIND, 32'h0000_0000);
    queue_random_set(3);
    queue_random_set(2);
    queue_random_set(4);
    drain();

    // Full store with no last flag: the 64th body closes the set.
    write_reg(dsga_pkg::CFG_GRAV, 32'h0010_0000);
    write_reg(dsga_pkg::CFG_MIND, 32'd655);
    for (int k = 0; k < dsga_pkg::MAX_BODIES; k++) begin
      add_body(mk_body(rand_word(10), rand_word(10), rand_word(10), $urandom,
                       rand_word(10), rand_word(10), rand_word(10),
                       k == 0 || k == 1 || k == 63,
                       k == 0 || k == 1 || k == 62 || k == 63, 1'b0));
    end
    queue_random_set(3);
    drain();

    // Random settings, random sets.
    for (int p = 0; p < 3; p++) begin
      write_reg(dsga_pkg::CFG_GRAV,
                ($urandom_range(1) != 0) ? $urandom : $urandom_range(32'h0400_0000));
      write_reg(dsga_pkg::CFG_MIND,
                ($urandom_range(1) != 0) ? $urandom_range(32'h0001_0000, 1) : $urandom);
      budget = 0;
      while (budget < 15) begin
        n = $urandom_range(1, 5);
        queue_random_set(n);
        budget += n;
      end
      drain();
    end

    if (fail_count == 0 && accel_queue.size() == 0) begin
      $display("direct_sum_gravity_accumulator test passed");
    end else begin
      $display("direct_sum_gravity_accumulator test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/dsga_pkg.sv
hw/rtl/dsga_in_if.sv
hw/rtl/dsga_out_if.sv
hw/rtl/dsga_unit.sv
hw/rtl/direct_sum_gravity_accumulator.sv
tb/sv/tb_direct_sum_gravity_accumulator.sv
